// File: hdl/pjq_pkg.sv
// pjq_pkg: types and constants for the priority job queue
// transfer payload structs, opcode and status codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package pjq_pkg;

    localparam int PRIO_W                = 8;
    localparam int DATA_W                = 32;
    localparam int COUNT_W               = 5;
    localparam int DEFAULT_QUEUE_DEPTH   = 16;
    localparam int DEFAULT_PAYLOAD_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_ZERO_PRIO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [PRIO_W-1:0]   in_priority;
        logic [DATA_W-1:0]   in_payload;
    } pjq_in_t;

    typedef struct packed {
        status_t             status;
        logic [PRIO_W-1:0]   out_priority;
        logic [DATA_W-1:0]   out_payload;
        logic [COUNT_W-1:0]  entry_count;
    } pjq_out_t;

endpackage

// File: hdl/priority_job_queue.sv
// priority_job_queue: bounded queue of jobs, most urgent (smallest priority) served first
// uses pjq_pkg; holds the slot memory and the scan/shift sequencer
`timescale 1ns / 1ps

// Jobs sit in one slot memory in arrival order; the block takes one operation at a
// time and s_ready is high only while the sequencer is idle. Enqueue, a refused
// enqueue, an operation on an empty queue and the unused opcode go straight from
// idle to the finish state. Peek reads every queued entry once through the single
// read port and checks it with one comparator. Dequeue scans the same way and then
// moves every job behind the chosen one down a slot through the same port. A
// finished result waits in the output register while the next operation is already
// taken in.
module priority_job_queue
    import pjq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
    parameter int PAYLOAD_WIDTH = DEFAULT_PAYLOAD_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pjq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pjq_out_t m_data
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PRIO_W + PAYLOAD_WIDTH;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]        best_prio_reg, best_prio_next;
    logic [PAYLOAD_WIDTH-1:0] best_pay_reg, best_pay_next;
    logic                     deq_reg, deq_next;
    pjq_out_t                 res_reg, res_next;
    logic                     m_valid_reg, m_valid_next;
    pjq_out_t                 m_data_reg, m_data_next;
    logic [ENTRY_W-1:0]       rd_data_reg;

    logic                     mem_we;
    logic [IDX_W-1:0]         wr_addr;
    logic [ENTRY_W-1:0]       wr_data;
    logic [IDX_W-1:0]         rd_addr;

    logic [PRIO_W-1:0]        rd_prio;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic                     take;

    assign rd_prio = rd_data_reg[ENTRY_W-1 -: PRIO_W];
    assign rd_pay  = rd_data_reg[PAYLOAD_WIDTH-1:0];

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg       <= idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_pay_reg  <= best_pay_next;
        deq_reg       <= deq_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_pay_next  = best_pay_reg;
        deq_next       = deq_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        mem_we         = 1'b0;
        wr_addr        = IDX_W'(fill_reg);
        wr_data        = {s_data.in_priority, PAYLOAD_WIDTH'(s_data.in_payload)};
        rd_addr        = idx_reg + IDX_W'(1);
        take           = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_next.status       = STATUS_OK;
                    res_next.out_priority = '0;
                    res_next.out_payload  = '0;
                    state_next            = S_FINISH;
                    case (s_data.opcode)
                        OP_ENQUEUE: begin
                            if (s_data.in_priority == '0) begin
                                res_next.status = STATUS_ZERO_PRIO;
                            end else if (fill_reg == CNT_W'(QUEUE_DEPTH)) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQUEUE, OP_PEEK: begin
                            if (fill_reg == '0) begin
                                res_next.status = STATUS_EMPTY;
                            end else begin
                                rd_addr    = '0;
                                idx_next   = '0;
                                deq_next   = (s_data.opcode == OP_DEQUEUE);
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_next.status = STATUS_OK;
                        end
                    endcase
                    res_next.entry_count = COUNT_W'(fill_next);
                end
            end

            S_SCAN: begin
                // rd_data_reg holds the entry at idx_reg; first entry seeds the minimum
                take = (idx_reg == '0) || (rd_prio < best_prio_reg);
                if (take) begin
                    best_idx_next  = idx_reg;
                    best_prio_next = rd_prio;
                    best_pay_next  = rd_pay;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (CNT_W'(idx_reg) == fill_reg - CNT_W'(1)) begin
                    res_next.status       = STATUS_OK;
                    res_next.out_priority = best_prio_next;
                    res_next.out_payload  = DATA_W'(best_pay_next);
                    state_next            = S_FINISH;
                    if (deq_reg) begin
                        fill_next = fill_reg - CNT_W'(1);
                        // later entries move down one slot, oldest first
                        if (CNT_W'(best_idx_next) + CNT_W'(1) < fill_reg) begin
                            rd_addr    = best_idx_next + IDX_W'(1);
                            idx_next   = best_idx_next;
                            state_next = S_SHIFT;
                        end
                    end
                    res_next.entry_count = COUNT_W'(fill_next);
                end
            end

            S_SHIFT: begin
                // rd_data_reg holds the entry one slot above idx_reg
                mem_we   = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                rd_addr  = idx_reg + IDX_W'(2);
                idx_next = idx_reg + IDX_W'(1);
                if (CNT_W'(idx_reg) == fill_reg - CNT_W'(1)) begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
